### src/lpbg_pkg.sv
// Shared constants and types for the progress bar glyph generator.
package lpbg_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_PROGRESS = 1'b0,
      CSR_BAR_LENGTH   = 1'b1
   } csr_index_type;

   // field widths
   localparam int PROGRESS_W   = 8;
   localparam int BAR_LENGTH_W = 6;
   localparam int CODE_W       = 8;

   // display constants
   localparam logic [CODE_W-1:0] ADDR_CMD        = 8'hC0;
   localparam int                PIXELS_PER_CELL = 5;
   localparam logic [CODE_W-1:0] GLYPH_FULL      = CODE_W'(PIXELS_PER_CELL);
   localparam logic [CODE_W-1:0] GLYPH_EMPTY     = '0;

   // reset values of the registers
   localparam logic [PROGRESS_W-1:0]   MAX_PROGRESS_RESET = 8'd100;
   localparam logic [BAR_LENGTH_W-1:0] BAR_LENGTH_RESET   = 6'd16;

   // status from the scaling front end
   typedef struct packed {
      logic busy;
   } front_status_type;

endpackage

### src/lpbg_front.sv
// Front end: takes a progress value, scales it and divides by full scale bit-serially.
module lpbg_front #(
   parameter int MAX_LENGTH = 40,
   parameter int LEN_W      = 6,
   parameter int PIX_W      = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [lpbg_pkg::PROGRESS_W-1:0]     progress,
   input  logic [lpbg_pkg::PROGRESS_W-1:0]     max_progress,
   input  logic [lpbg_pkg::BAR_LENGTH_W-1:0]   bar_length,
   output lpbg_pkg::front_status_type          status,
   output logic                                push,
   output logic [PIX_W-1:0]                    push_pix,
   output logic [LEN_W-1:0]                    push_len,
   input  logic                                q_full
);
   import lpbg_pkg::*;

   localparam int CMP_W  = (LEN_W > BAR_LENGTH_W) ? LEN_W : BAR_LENGTH_W;
   localparam int STEP_W = $clog2(PIX_W + 1);

   logic                  active_ff, active_in;
   logic [STEP_W-1:0]     count_ff, count_in;
   logic [PIX_W-1:0]      dividend_ff, dividend_in;
   logic [PROGRESS_W-1:0] rem_ff, rem_in;
   logic [PROGRESS_W-1:0] divisor_ff, divisor_in;
   logic [LEN_W-1:0]      len_ff, len_in;

   logic [CMP_W-1:0]      len_cmp;
   logic [LEN_W-1:0]      len_sat;
   logic [PIX_W-1:0]      prod;
   logic [PIX_W-1:0]      prod_x5;
   logic [PROGRESS_W:0]   trial;
   logic                  fits;
   logic                  accept;

   assign accept = start && !active_ff;

   // saturate the bar length and scale the progress value by length and cell width
   always_comb begin
      len_cmp = (CMP_W'(bar_length) > CMP_W'(MAX_LENGTH)) ? CMP_W'(MAX_LENGTH)
                                                           : CMP_W'(bar_length);
      len_sat = LEN_W'(len_cmp);
      prod    = PIX_W'(progress) * PIX_W'(len_sat);
      prod_x5 = (prod << 2) + prod;
   end

   // one restoring division step per cycle
   always_comb begin
      trial = {rem_ff, dividend_ff[PIX_W-1]};
      fits  = trial >= {1'b0, divisor_ff};
   end

   always_comb begin
      active_in   = active_ff;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      len_in      = len_ff;
      if (accept) begin
         active_in   = 1'b1;
         count_in    = STEP_W'(PIX_W);
         dividend_in = prod_x5;
         rem_in      = '0;
         divisor_in  = (max_progress == '0) ? PROGRESS_W'(1) : max_progress;
         len_in      = len_sat;
      end else if (active_ff && count_ff != '0) begin
         count_in    = count_ff - STEP_W'(1);
         dividend_in = {dividend_ff[PIX_W-2:0], fits};
         rem_in      = fits ? PROGRESS_W'(trial - {1'b0, divisor_ff})
                            : PROGRESS_W'(trial);
      end else if (active_ff && !q_full) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      len_ff      <= len_in;
   end

   // quotient is complete once all steps are done
   assign push        = active_ff && (count_ff == '0) && !q_full;
   assign push_pix    = dividend_ff;
   assign push_len    = len_ff;
   assign status.busy = active_ff;

endmodule

### src/lpbg_queue.sv
// Two-entry queue between the scaling front end and the glyph emitter.
module lpbg_queue #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push = push && (count_ff != 2'd2);
   assign do_pop  = pop && (count_ff != 2'd0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];

endmodule

### src/lpbg_back.sv
// Back end: emits the address command and one glyph code per cell.
module lpbg_back #(
   parameter int LEN_W = 6,
   parameter int PIX_W = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_not_empty,
   input  logic [PIX_W-1:0]              q_pix,
   input  logic [LEN_W-1:0]              q_len,
   output logic                          q_pop,
   output logic                          rsp_valid,
   output logic                          rsp_is_command,
   output logic [lpbg_pkg::CODE_W-1:0]   rsp_code,
   output logic                          rsp_last
);
   import lpbg_pkg::*;

   typedef enum logic {
      ST_CMD,
      ST_CELLS
   } state_type;

   state_type          state_ff;
   logic [PIX_W-1:0]   pix_ff;
   logic [PIX_W-1:0]   cell_start_ff;
   logic [LEN_W-1:0]   left_ff;
   logic               valid_ff;
   logic               is_cmd_ff;
   logic [CODE_W-1:0]  code_ff;
   logic               last_ff;

   logic [PIX_W:0]     cell_end;
   logic [CODE_W-1:0]  cell_code;
   logic [PIX_W-1:0]   partial;

   assign q_pop = (state_ff == ST_CMD) && q_not_empty;

   // glyph for the current cell: full, empty or the partial pixel count
   always_comb begin
      cell_end = {1'b0, cell_start_ff} + (PIX_W + 1)'(PIXELS_PER_CELL);
      partial  = pix_ff - cell_start_ff;
      if (cell_end > {1'b0, pix_ff}) begin
         cell_code = (cell_start_ff > pix_ff) ? GLYPH_EMPTY : CODE_W'(partial);
      end else begin
         cell_code = GLYPH_FULL;
      end
   end

   // sequencer with registered result outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CMD;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            ST_CMD: begin
               if (q_not_empty) begin
                  valid_ff <= 1'b1;
                  if (q_len != '0) begin
                     state_ff <= ST_CELLS;
                  end
               end
            end
            ST_CELLS: begin
               valid_ff <= 1'b1;
               if (left_ff == LEN_W'(1)) begin
                  state_ff <= ST_CMD;
               end
            end
            default: begin
               state_ff <= ST_CMD;
            end
         endcase
      end
      // datapath registers
      case (state_ff)
         ST_CMD: begin
            pix_ff        <= q_pix;
            left_ff       <= q_len;
            cell_start_ff <= '0;
            is_cmd_ff     <= 1'b1;
            code_ff       <= ADDR_CMD;
            last_ff       <= (q_len == '0);
         end
         ST_CELLS: begin
            left_ff       <= left_ff - LEN_W'(1);
            cell_start_ff <= PIX_W'(cell_end);
            is_cmd_ff     <= 1'b0;
            code_ff       <= cell_code;
            last_ff       <= (left_ff == LEN_W'(1));
         end
         default: begin
            is_cmd_ff <= 1'b0;
         end
      endcase
   end

   assign rsp_valid      = valid_ff;
   assign rsp_is_command = is_cmd_ff;
   assign rsp_code       = code_ff;
   assign rsp_last       = last_ff;

endmodule

### src/lcd_progress_bar_glyph_generator.sv
// Top level of the progress bar glyph generator.
//
// Each progress value accepted (start high while busy is low) renders one bar: the
// address command 0xC0 followed by one glyph code per cell, one result per cycle on
// rsp_valid with rsp_last on the final one. Results cannot be held off. The front end
// scales progress by bar length and cell width and divides by full scale one quotient
// bit a cycle, so busy stays high until every quotient bit is done and the result is
// pushed, longer while the queue is full; no new item is taken until busy falls. The
// emitter produces bar length plus one results per item, one per cycle, so the
// sustained rate is set by the slower of the front end and the emitter. A two-entry
// queue lets the next item be divided while the current bar is emitted. With the
// emitter idle, the command reaches the outputs once the quotient has been pushed
// into the queue and the emitter has registered it from there.
module lcd_progress_bar_glyph_generator #(
   parameter int MAX_LENGTH = 40
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lpbg_pkg::PROGRESS_W-1:0]     req_progress,
   output logic                                rsp_valid,
   output logic                                rsp_is_command,
   output logic [lpbg_pkg::CODE_W-1:0]         rsp_code,
   output logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [lpbg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lpbg_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lpbg_pkg::*;

   localparam int LEN_W = $clog2(MAX_LENGTH + 1);
   localparam int PIX_W = $clog2(((1 << PROGRESS_W) - 1) * MAX_LENGTH * PIXELS_PER_CELL + 1);
   localparam int Q_W   = PIX_W + LEN_W;

   logic [PROGRESS_W-1:0]   max_progress_ff;
   logic [BAR_LENGTH_W-1:0] bar_length_ff;

   front_status_type        front_status;
   logic                    push;
   logic [PIX_W-1:0]        push_pix;
   logic [LEN_W-1:0]        push_len;
   logic                    q_full;
   logic                    q_pop;
   logic                    q_not_empty;
   logic [Q_W-1:0]          q_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_progress_ff <= MAX_PROGRESS_RESET;
         bar_length_ff   <= BAR_LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_PROGRESS: max_progress_ff <= PROGRESS_W'(csr_wdata);
            CSR_BAR_LENGTH:   bar_length_ff   <= BAR_LENGTH_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   lpbg_front #(
      .MAX_LENGTH (MAX_LENGTH),
      .LEN_W      (LEN_W),
      .PIX_W      (PIX_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .progress     (req_progress),
      .max_progress (max_progress_ff),
      .bar_length   (bar_length_ff),
      .status       (front_status),
      .push         (push),
      .push_pix     (push_pix),
      .push_len     (push_len),
      .q_full       (q_full)
   );

   lpbg_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_pix, push_len}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   lpbg_back #(
      .LEN_W (LEN_W),
      .PIX_W (PIX_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_pix          (q_data[Q_W-1:LEN_W]),
      .q_len          (q_data[LEN_W-1:0]),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_is_command (rsp_is_command),
      .rsp_code       (rsp_code),
      .rsp_last       (rsp_last)
   );

   assign busy = front_status.busy;

endmodule

### bench/tb_lcd_progress_bar_glyph_generator.sv
// Self-checking testbench for the progress bar glyph generator: directed and random progress.
`timescale 1ns / 100ps

module tb_lcd_progress_bar_glyph_generator;
   import lpbg_pkg::*;

   localparam int BAR_MAX      = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASE_ITEMS  = 39;
   localparam int PHASE_COUNT  = 9;

   // one expected result: address command or glyph code
   typedef struct packed {
      logic              is_command;
      logic [CODE_W-1:0] code;
      logic              last;
   } glyph_result_type;

   // bar renderer model and queue of expected command/glyph transfers
   class bar_scoreboard;
      glyph_result_type           expected_glyphs[$];
      logic [PROGRESS_W-1:0]      full_scale;
      logic [BAR_LENGTH_W-1:0]    cell_count;
      int                         errors;

      function new();
         full_scale = MAX_PROGRESS_RESET;
         cell_count = BAR_LENGTH_RESET;
         errors     = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_MAX_PROGRESS: full_scale = data;
            CSR_BAR_LENGTH:   cell_count = data[BAR_LENGTH_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_glyphs.size();
      endfunction

      // render one bar: command, then full / partial / empty cells
      function void note_progress(logic [PROGRESS_W-1:0] progress);
         int unsigned      divisor;
         int unsigned      cells;
         int unsigned      pixels;
         int unsigned      prog_value;
         int unsigned      cell_start;
         glyph_result_type g;
         prog_value = progress;
         divisor    = (full_scale == 0) ? 1 : full_scale;
         cells      = (cell_count > BAR_MAX) ? BAR_MAX : cell_count;
         pixels     = (prog_value * cells * PIXELS_PER_CELL) / divisor;
         g.is_command = 1'b1;
         g.code       = ADDR_CMD;
         g.last       = (cells == 0);
         expected_glyphs.push_back(g);
         for (int unsigned i = 0; i < cells; i++) begin
            cell_start   = i * PIXELS_PER_CELL;
            g.is_command = 1'b0;
            if (cell_start + PIXELS_PER_CELL <= pixels) begin
               g.code = GLYPH_FULL;
            end else if (cell_start > pixels) begin
               g.code = GLYPH_EMPTY;
            end else begin
               g.code = CODE_W'(pixels % PIXELS_PER_CELL);
            end
            g.last = (i + 1 == cells);
            expected_glyphs.push_back(g);
         end
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      // compare one output transfer against the oldest expectation
      task check_result(logic is_command, logic [CODE_W-1:0] code, logic last);
         glyph_result_type g;
         if (expected_glyphs.size() == 0) begin
            report_mismatch($sformatf("unexpected result cmd=%0b code=%0h last=%0b",
                                      is_command, code, last));
            return;
         end
         g = expected_glyphs.pop_front();
         if (is_command !== g.is_command)
            report_mismatch($sformatf("is_command %0b, expected %0b", is_command, g.is_command));
         if (code !== g.code)
            report_mismatch($sformatf("code %0h, expected %0h", code, g.code));
         if (last !== g.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, g.last));
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [PROGRESS_W-1:0]   req_progress;
   logic                    rsp_valid;
   logic                    rsp_is_command;
   logic [CODE_W-1:0]       rsp_code;
   logic                    rsp_last;
   logic                    csr_write;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   bar_scoreboard board;
   int            cycle_count = 0;
   int            sender_idle_pct = 0;

   lcd_progress_bar_glyph_generator #(
      .MAX_LENGTH(BAR_MAX)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_progress   (req_progress),
      .rsp_valid      (rsp_valid),
      .rsp_is_command (rsp_is_command),
      .rsp_code       (rsp_code),
      .rsp_last       (rsp_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // output monitor and cycle counter
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_valid) board.check_result(rsp_is_command, rsp_code, rsp_last);
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   // one progress transfer; called and returns just after a falling edge
   task send_progress(input logic [PROGRESS_W-1:0] progress);
      while ($urandom_range(99) < sender_idle_pct) begin
         start        = 1'b0;
         req_progress = PROGRESS_W'($urandom);
         @(negedge clock);
      end
      start        = 1'b1;
      req_progress = progress;
      do @(posedge clock); while (busy);
      board.note_progress(progress);
      @(negedge clock);
   endtask

   // wait until every expected result has arrived and the block has settled
   task wait_drain();
      start = 1'b0;
      do @(posedge clock); while (board.pending() != 0 || busy);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_write = 1'b0;
      board.set_register(idx, data);
   endtask

   task configure(input logic [CSR_DATA_W-1:0] max_data, input logic [CSR_DATA_W-1:0] len_data);
      wait_drain();
      write_register(CSR_MAX_PROGRESS, max_data);
      write_register(CSR_BAR_LENGTH, len_data);
   endtask

   initial begin
      int tmp;
      int full;
      board        = new();
      reset        = 1'b1;
      start        = 1'b0;
      req_progress = '0;
      csr_write    = 1'b0;
      csr_index    = CSR_MAX_PROGRESS;
      csr_wdata    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, cell edge at 50, above full scale
      send_progress(8'd0);
      send_progress(8'd50);
      send_progress(8'd100);
      send_progress(8'd101);
      send_progress(8'd255);
      send_progress(8'd1);
      send_progress(8'd99);
      send_progress(8'd37);
      // zero full scale, length above the maximum (upper data bits set too)
      configure(8'd0, 8'hFF);
      send_progress(8'd0);
      send_progress(8'd1);
      send_progress(8'd255);
      // widest bar at largest full scale; 51 lands exactly on a cell edge
      configure(8'd255, 8'd40);
      send_progress(8'd0);
      send_progress(8'd255);
      send_progress(8'd128);
      send_progress(8'd51);
      // empty bar: command only, marked last
      configure(8'd7, 8'd0);
      send_progress(8'd0);
      send_progress(8'd200);
      // single cell, full scale of one
      configure(8'd1, 8'd1);
      send_progress(8'd0);
      send_progress(8'd1);

      // random phases with varying settings and sender idling
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: configure(8'd255, 8'd40);
            1: configure(8'd1, 8'd41);
            2: configure(8'd0, 8'd0);
            default: configure(($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                               ($urandom_range(3) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, BAR_MAX)));
         endcase
         case (phase % 3)
            0: sender_idle_pct = 0;
            1: sender_idle_pct = 88;
            default: sender_idle_pct = 28;
         endcase
         full = (board.full_scale == 0) ? 1 : board.full_scale;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // bias some values toward the full-scale boundary
            if ($urandom_range(9) < 3) begin
               tmp = full + $urandom_range(0, 6) - 3;
               if (tmp < 0) tmp = 0;
               if (tmp > 255) tmp = 255;
            end else begin
               tmp = $urandom_range(0, 255);
            end
            send_progress(PROGRESS_W'(tmp));
         end
      end

      wait_drain();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### lcd_progress_bar_glyph_generator.f
src/lpbg_pkg.sv
src/lpbg_front.sv
src/lpbg_queue.sv
src/lpbg_back.sv
src/lcd_progress_bar_glyph_generator.sv
bench/tb_lcd_progress_bar_glyph_generator.sv
